@@ sv/twr_tof_pkg.sv @@
package twr_tof_pkg;

  localparam int STAMP_BYTES = 4;
  localparam int STAMP_W     = 32;
  localparam int DEN_W       = 34;
  localparam int PROD_W      = 64;
  localparam int FT_W        = 33;
  localparam int QBITS       = 33;
  localparam int LIMIT_W     = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd213;

  localparam int RM_BITS = (8 * STAMP_BYTES >= STAMP_W) ? STAMP_W : 8 * STAMP_BYTES;
  localparam logic [STAMP_W-1:0] REMOTE_MASK =
    (RM_BITS >= STAMP_W) ? {STAMP_W{1'b1}} : STAMP_W'((64'd1 << RM_BITS) - 64'd1);

  // payload handed from the front end to the divider
  typedef struct packed {
    logic              vld;
    logic [PROD_W-1:0] mag;
    logic [DEN_W-1:0]  den;
    logic              neg;
  } tof_num_t;

endpackage

@@ sv/twr_time_of_flight_core.sv @@
// Time-of-flight core for asymmetric double-sided two-way ranging.
// Input channel: one beat carries the six 32-bit stamps of an exchange
// (in_valid / in_stall). Output channel: one beat per input beat with
// out_flight_time (33-bit signed, device units), out_is_near and
// out_zero_divisor (out_valid / out_stall).
// Config channel: cfg_valid / cfg_ready / cfg_data writes the near limit;
// cfg_ready is always high. Write it only while the core is empty.
// Throughput: one beat per cycle while out_stall does not hold the output.
// Pipeline from accepted input beat to the output beat: three front stages
// (intervals, two 32x32 products, magnitude), one divider entry stage, 33
// restoring divider stages one quotient bit each, and the output register.
// A stalled output holds the whole pipeline: in_stall rises whenever an
// output beat is waiting under out_stall, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the near limit with 213.
module twr_time_of_flight_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_remote_poll_tx,
  input  logic [31:0] in_remote_resp_rx,
  input  logic [31:0] in_remote_final_tx,
  input  logic [31:0] in_local_poll_rx,
  input  logic [31:0] in_local_resp_tx,
  input  logic [31:0] in_local_final_rx,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [32:0] out_flight_time,
  output logic        out_is_near,
  output logic        out_zero_divisor,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic en;
  twr_tof_pkg::tof_num_t num;
  logic        q_vld, ovf, neg, zden;
  logic [32:0] quot;
  logic [15:0] limit_r;
  logic        out_vld_r, near_r, zero_r;
  logic [32:0] ft_r;
  logic [32:0] sat, ft_nxt;
  logic        near_nxt;

  assign en        = !(out_vld_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= twr_tof_pkg::LIMIT_RST;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  twr_tof_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
    .r_poll_tx(in_remote_poll_tx), .r_resp_rx(in_remote_resp_rx),
    .r_final_tx(in_remote_final_tx), .l_poll_rx(in_local_poll_rx),
    .l_resp_tx(in_local_resp_tx), .l_final_rx(in_local_final_rx),
    .num(num)
  );

  twr_tof_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .num(num),
    .q_vld(q_vld), .quot(quot), .ovf(ovf), .neg(neg), .zden(zden)
  );

  // saturate, apply sign, near test
  always_comb begin
    if (neg) begin
      sat = (ovf || quot > 33'h1_0000_0000) ? 33'h1_0000_0000 : quot;
    end else begin
      sat = (ovf || quot > 33'h0_FFFF_FFFF) ? 33'h0_FFFF_FFFF : quot;
    end
    if (zden) begin
      ft_nxt   = '0;
      near_nxt = 1'b0;
    end else if (neg && sat != '0) begin
      ft_nxt   = 33'(~sat + 33'd1);
      near_nxt = 1'b1;
    end else begin
      ft_nxt   = sat;
      near_nxt = sat < 33'(limit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ft_r   <= ft_nxt;
      near_r <= near_nxt;
      zero_r <= zden;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_flight_time  = ft_r;
  assign out_is_near      = near_r;
  assign out_zero_divisor = zero_r;

endmodule

@@ sv/twr_tof_front.sv @@
module twr_tof_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [31:0]                  r_poll_tx,
  input  logic [31:0]                  r_resp_rx,
  input  logic [31:0]                  r_final_tx,
  input  logic [31:0]                  l_poll_rx,
  input  logic [31:0]                  l_resp_tx,
  input  logic [31:0]                  l_final_rx,
  output twr_tof_pkg::tof_num_t        num
);

  logic        s1_vld_r, s2_vld_r, s3_vld_r;
  logic [31:0] ra_r, rb_r, da_r, db_r;
  logic [twr_tof_pkg::DEN_W-1:0]  den1_r, den2_r, den3_r;
  logic [twr_tof_pkg::PROD_W-1:0] p_r, q_r, mag_r;
  logic        neg_r;
  logic [31:0] rpt, rrr, rft;
  logic [31:0] ra_w, rb_w, da_w, db_w;

  assign rpt = r_poll_tx  & twr_tof_pkg::REMOTE_MASK;
  assign rrr = r_resp_rx  & twr_tof_pkg::REMOTE_MASK;
  assign rft = r_final_tx & twr_tof_pkg::REMOTE_MASK;

  // intervals wrap at 32 bits
  assign ra_w = rrr - rpt;
  assign da_w = rft - rrr;
  assign rb_w = l_final_rx - l_resp_tx;
  assign db_w = l_resp_tx - l_poll_rx;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // stage 1: intervals, stage 2: products, stage 3: magnitude and sign
  always_ff @(posedge clk) begin
    if (en) begin
      ra_r   <= ra_w;
      da_r   <= da_w;
      rb_r   <= rb_w;
      db_r   <= db_w;
      den1_r <= 34'(ra_w) + 34'(da_w) + 34'(rb_w) + 34'(db_w);
      p_r    <= 64'(ra_r) * 64'(rb_r);
      q_r    <= 64'(da_r) * 64'(db_r);
      den2_r <= den1_r;
      neg_r  <= (p_r < q_r);
      mag_r  <= (p_r >= q_r) ? (p_r - q_r) : (q_r - p_r);
      den3_r <= den2_r;
    end
  end

  assign num.vld = s3_vld_r;
  assign num.mag = mag_r;
  assign num.den = den3_r;
  assign num.neg = neg_r;

endmodule

@@ sv/twr_tof_div.sv @@
module twr_tof_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  twr_tof_pkg::tof_num_t               num,
  output logic                                q_vld,
  output logic [twr_tof_pkg::QBITS-1:0]       quot,
  output logic                                ovf,
  output logic                                neg,
  output logic                                zden
);

  localparam int N = twr_tof_pkg::QBITS;
  localparam int DW = twr_tof_pkg::DEN_W;

  logic          vld_r  [0:N];
  logic [DW-1:0] rem_r  [0:N];
  logic [N-1:0]  mlo_r  [0:N];
  logic [N-1:0]  q_r    [0:N];
  logic [DW-1:0] den_r  [0:N];
  logic          ovf_r  [0:N];
  logic          neg_r  [0:N];

  // entry: quotients of 2^33 or more are flagged, the rest fit in 33 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= num.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(num.mag[63:N]);
      mlo_r[0] <= num.mag[N-1:0];
      q_r[0]   <= '0;
      den_r[0] <= num.den;
      ovf_r[0] <= DW'(num.mag[63:N]) >= num.den;
      neg_r[0] <= num.neg;
    end
  end

  // one restoring step per stage, MSB first
  for (genvar j = 0; j < N; j++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_r[j], mlo_r[j][N-1]};
    assign ge    = trial >= {1'b0, den_r[j]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? DW'(trial - {1'b0, den_r[j]}) : DW'(trial);
        mlo_r[j+1] <= {mlo_r[j][N-2:0], 1'b0};
        q_r[j+1]   <= {q_r[j][N-2:0], ge};
        den_r[j+1] <= den_r[j];
        ovf_r[j+1] <= ovf_r[j];
        neg_r[j+1] <= neg_r[j];
      end
    end
  end

  assign q_vld = vld_r[N];
  assign quot  = q_r[N];
  assign ovf   = ovf_r[N];
  assign neg   = neg_r[N];
  assign zden  = (den_r[N] == '0);

endmodule

@@ sv/twr_tof_chk.sv @@
module twr_tof_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [32:0] out_flight_time,
  input logic        out_is_near,
  input logic        out_zero_divisor
);

  // a waiting beat stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("output beat dropped");

  // zero divisor beat carries zero and is not near
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_divisor |-> out_flight_time == '0 && !out_is_near)
    else $error("bad zero divisor beat");

  // negative flight time counts as near
  a_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flight_time[32] |-> out_is_near)
    else $error("negative flight time not near");

  // input is held back only by a stalled output beat
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall) else $error("spurious input stall");

endmodule

bind twr_time_of_flight_core twr_tof_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_flight_time(out_flight_time),
  .out_is_near(out_is_near), .out_zero_divisor(out_zero_divisor)
);

@@ test/twr_time_of_flight_core_tb.sv @@
module twr_time_of_flight_core_tb;

  // one ranging exchange as carried by an input beat
  typedef struct packed {
    logic [31:0] r_poll_tx;
    logic [31:0] r_resp_rx;
    logic [31:0] r_final_tx;
    logic [31:0] l_poll_rx;
    logic [31:0] l_resp_tx;
    logic [31:0] l_final_rx;
  } exchange_t;

  typedef struct packed {
    logic [32:0] flight_time;
    logic        is_near;
    logic        zero_div;
  } tof_result_t;

  localparam int LATENCY     = 38;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  exchange_t   in_x;
  logic        out_valid;
  logic        out_stall;
  logic signed [32:0] out_flight_time;
  logic        out_is_near;
  logic        out_zero_divisor;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  logic [twr_tof_pkg::LIMIT_W-1:0] near_limit;
  tof_result_t        tof_expected[$];
  int                 mismatch_cnt;
  int                 cycle_cnt;
  int                 stall_mode;

  twr_time_of_flight_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_remote_poll_tx  (in_x.r_poll_tx),
    .in_remote_resp_rx  (in_x.r_resp_rx),
    .in_remote_final_tx (in_x.r_final_tx),
    .in_local_poll_rx   (in_x.l_poll_rx),
    .in_local_resp_tx   (in_x.l_resp_tx),
    .in_local_final_rx  (in_x.l_final_rx),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_flight_time    (out_flight_time),
    .out_is_near        (out_is_near),
    .out_zero_divisor   (out_zero_divisor),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // timeout watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // exact ADS-TWR flight time with saturation and near flag
  function automatic tof_result_t tof_compute(exchange_t x, logic [15:0] lim);
    tof_result_t res;
    logic [31:0] rpt, rrr, rft;
    logic [31:0] ra, rb, da, db;
    logic [63:0] den, p, q, mag, quot;
    logic        neg;
    rpt = x.r_poll_tx & twr_tof_pkg::REMOTE_MASK;
    rrr = x.r_resp_rx & twr_tof_pkg::REMOTE_MASK;
    rft = x.r_final_tx & twr_tof_pkg::REMOTE_MASK;
    ra = rrr - rpt;
    da = rft - rrr;
    rb = x.l_final_rx - x.l_resp_tx;
    db = x.l_resp_tx - x.l_poll_rx;
    den = 64'(ra) + 64'(rb) + 64'(da) + 64'(db);
    p = 64'(ra) * 64'(rb);
    q = 64'(da) * 64'(db);
    res = '0;
    if (den == 0) begin
      res.zero_div = 1'b1;
      return res;
    end
    neg = p < q;
    mag = neg ? q - p : p - q;
    quot = mag / den;
    if (neg && quot > 64'h1_0000_0000) quot = 64'h1_0000_0000;
    if (!neg && quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
    if (neg && quot != 0) begin
      res.flight_time = 33'(64'd0 - quot);
      res.is_near = 1'b1;
    end else begin
      res.flight_time = quot[32:0];
      res.is_near = quot < 64'(lim);
    end
    return res;
  endfunction

  // send one beat, with an idle gap first when gap is above zero;
  // valid stays high after the beat so that beats can follow back to back
  task automatic send_exchange(exchange_t x, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_x <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tof_expected.push_back(tof_compute(x, near_limit));
    @(negedge clk);
  endtask

  task automatic write_near_limit(logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    near_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (tof_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // receiver stall pattern: mode changes now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    tof_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.flight_time = out_flight_time;
      got.is_near = out_is_near;
      got.zero_div = out_zero_divisor;
      if (tof_expected.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected beat: ft=%0d", out_flight_time);
      end else begin
        want = tof_expected.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp ft=%0d near=%b zd=%b got ft=%0d near=%b zd=%b",
                     $signed(want.flight_time), want.is_near, want.zero_div,
                     $signed(got.flight_time), got.is_near, got.zero_div);
        end
      end
    end
  end

  function automatic exchange_t make_exchange(logic [31:0] t0, logic [31:0] l0,
                                              logic [31:0] ra, logic [31:0] db,
                                              logic [31:0] da, logic [31:0] rb);
    exchange_t x;
    x.r_poll_tx = t0;
    x.r_resp_rx = t0 + ra;
    x.r_final_tx = t0 + ra + da;
    x.l_poll_rx = l0;
    x.l_resp_tx = l0 + db;
    x.l_final_rx = l0 + db + rb;
    return x;
  endfunction

  function automatic logic [31:0] rand_interval;
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 16);
      1: return $urandom_range(0, 65535);
      2: return $urandom_range(0, 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // field extremes, zero divisor, negative flight, wrap
  task automatic test_directed;
    exchange_t x;
    send_exchange('0, 0);
    send_exchange('1, 0);
    send_exchange({6{32'h8000_0000}}, 0);
    x = make_exchange(32'hFFFF_FFF0, 32'hFFFF_FF00, 1000, 400, 400, 1000);
    send_exchange(x, 0);
    x = make_exchange(5, 7, 10, 5000, 5000, 10);
    send_exchange(x, 0);
    x = make_exchange(0, 0, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF);
    send_exchange(x, 0);
    x = make_exchange(0, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_exchange(x, 0);
    x = make_exchange(0, 0, 1, 1, 0, 0);
    send_exchange(x, 0);
    x = make_exchange(0, 0, 0, 0, 0, 1);
    send_exchange(x, 0);
    x = make_exchange(100, 200, 30000, 29000, 29000, 30000);
    send_exchange(x, 0);
    x = make_exchange(100, 200, 30426, 30000, 30000, 30426);
    send_exchange(x, 1);
    x = make_exchange(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_exchange(x, 2);
    x = '1;
    x.r_poll_tx = 0;
    x.l_poll_rx = 0;
    send_exchange(x, 0);
  endtask

  // near limit sweep with a few items each
  task automatic test_near_limit;
    logic [15:0] lims[4] = '{16'd0, 16'hFFFF, 16'd1, 16'd213};
    foreach (lims[i]) begin
      drain();
      write_near_limit(lims[i]);
      repeat (8)
        send_exchange(make_exchange($urandom, $urandom, 1000 + $urandom_range(0, 70000),
                                    1000, 1000, 1000 + $urandom_range(0, 70000)), 0);
    end
  endtask

  // random exchanges in bursts, mostly well-formed ranging, some raw noise
  task automatic test_random;
    int burst, gap;
    exchange_t x;
    int n;
    n = 0;
    while (n < 1000) begin
      if (n % 250 == 0) begin
        drain();
        write_near_limit($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 600)));
      end
      burst = $urandom_range(1, 30);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < burst && n < 1000; i++) begin
        if ($urandom_range(0, 4) == 0)
          x = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        else
          x = make_exchange($urandom, $urandom, rand_interval(), rand_interval(),
                            rand_interval(), rand_interval());
        send_exchange(x, i == 0 ? gap : 0);
        n++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cycle_cnt = 0;
    mismatch_cnt = 0;
    stall_mode = 0;
    near_limit = twr_tof_pkg::LIMIT_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_near_limit();
    test_random();
    drain();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ twr_time_of_flight_core.f @@
sv/twr_tof_pkg.sv
sv/twr_tof_front.sv
sv/twr_tof_div.sv
sv/twr_time_of_flight_core.sv
sv/twr_tof_chk.sv
test/twr_time_of_flight_core_tb.sv
